@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ordered list core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define OLAR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// When the condition holds, the expression holds in the next cycle.
`define OLAR_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ rtl/core/olar_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered list package
// Field widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package olar_pkg;

   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 6;
   localparam int COUNT_W   = 7;
   localparam int CAP_OUT_W = 7;

   localparam logic ACTION_APPEND = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE,
      STATUS_NOT_FOUND,
      STATUS_FULL
   } status_type;

   // Commands broadcast to every cell of the chain.
   typedef struct packed {
      logic                      compare;
      logic                      append;
      logic                      shift;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

@@ rtl/core/olar_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one list operation per item.
// ----------------------------------------------------------------------------
interface olar_req_if;
   import olar_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);

endinterface

@@ rtl/core/olar_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the outcome of one list operation.
// ----------------------------------------------------------------------------
interface olar_rsp_if;
   import olar_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [POS_W-1:0]     position;
   logic [COUNT_W-1:0]   item_count;
   logic [CAP_OUT_W-1:0] capacity_now;

   modport source (output valid, status, position, item_count, capacity_now, input ready);
   modport sink   (input valid, status, position, item_count, capacity_now, output ready);

endinterface

@@ rtl/core/ordered_list_append_remove_core.sv @@
// ----------------------------------------------------------------------------
// Ordered list append/remove core
// Keeps an ordered list of signed 32-bit entries with a count and a tracked
// capacity; appends at the end and removes the first entry of a given value.
//
//   Channel | Direction | Handshake         | Payload
//   req_    | in        | valid/ready       | action, value
//   rsp_    | out       | valid/ready       | status, position, item_count,
//           |           |                   | capacity_now
//
// At acceptance every cell registers its compare against the value; in the
// execute state the cells shift or write while the result is loaded into the
// output register, and the first-match ripple through the cell chain is
// evaluated in that step. A new item is accepted while a result still waits;
// the execute step holds until the output register frees.
// Reset is synchronous and leaves the list empty at minimum capacity.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_list_append_remove_core #(
   parameter int DEPTH        = 64,
   parameter int MIN_CAPACITY = 4
) (
   input logic        clock,
   input logic        reset,
   olar_req_if.sink   req_chan,
   olar_rsp_if.source rsp_chan
);
   import olar_pkg::*;

   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CAP_MAX = (DEPTH > MIN_CAPACITY) ? DEPTH : MIN_CAPACITY;
   localparam int CAP_W   = $clog2(CAP_MAX + 1);
   localparam int GW      = CAP_W + 1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CAP_W-1:0]          cap_ff, cap_in;
   logic                      action_ff, action_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic [POS_W-1:0]          position_ff, position_in;
   logic [COUNT_W-1:0]        item_count_ff, item_count_in;
   logic [CAP_OUT_W-1:0]      capacity_ff, capacity_in;

   cell_ctl_type              ctl;
   logic                      accept;
   logic                      exec_go;
   logic                      hit_found;
   logic [IDX_W-1:0]          hit_pos;
   logic [GW-1:0]             count_x, cap_x, cap_dbl;
   logic [CNT_W-1:0]          cnt_dec;
   logic [CAP_W-1:0]          cap_half;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.position     = position_ff;
   assign rsp_chan.item_count   = item_count_ff;
   assign rsp_chan.capacity_now = capacity_ff;

   assign accept  = req_chan.valid && (state_ff == ST_IDLE);
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   assign ctl.compare = accept;
   assign ctl.append  = exec_go && (action_ff == ACTION_APPEND)
                        && (count_ff != CNT_W'(DEPTH));
   assign ctl.shift   = exec_go && (action_ff == ACTION_REMOVE);
   assign ctl.value   = (state_ff == ST_IDLE) ? req_chan.value : value_ff;

   olar_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .count    (count_ff),
      .found    (hit_found),
      .position (hit_pos)
   );

   assign count_x  = GW'(count_ff);
   assign cap_x    = GW'(cap_ff);
   assign cap_dbl  = cap_x << 1;
   assign cnt_dec  = count_ff - CNT_W'(1);
   assign cap_half = cap_ff >> 1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      action_in     = action_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      position_in   = position_ff;
      item_count_in = item_count_ff;
      capacity_in   = capacity_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (accept) begin
         state_in  = ST_EXEC;
         action_in = req_chan.action;
         value_in  = req_chan.value;
      end

      if (exec_go) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         status_in    = STATUS_DONE;
         position_in  = '0;
         if (action_ff == ACTION_APPEND) begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               if (count_x >= cap_x) begin
                  cap_in = (cap_dbl > GW'(DEPTH)) ? CAP_W'(DEPTH) : CAP_W'(cap_dbl);
               end
               count_in    = count_ff + CNT_W'(1);
               position_in = POS_W'(IDX_W'(count_ff));
            end
         end else begin
            if (!hit_found) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               count_in    = cnt_dec;
               position_in = POS_W'(hit_pos);
               if ((GW'(cnt_dec) < (cap_x >> 2)) && (cap_x > GW'(MIN_CAPACITY))) begin
                  cap_in = (GW'(cap_half) < GW'(MIN_CAPACITY)) ?
                           CAP_W'(MIN_CAPACITY) : cap_half;
               end
            end
         end
         item_count_in = COUNT_W'(count_in);
         capacity_in   = CAP_OUT_W'(cap_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_W'(MIN_CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      position_ff   <= position_in;
      item_count_ff <= item_count_in;
      capacity_ff   <= capacity_in;
   end

   `OLAR_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH),
                "entry count above depth")
   `OLAR_ASSERT(a_count_in_cap, clock, reset, count_x <= cap_x,
                "entry count above tracked capacity")
   `OLAR_ASSERT(a_cap_floor, clock, reset, cap_ff >= CAP_W'(MIN_CAPACITY),
                "capacity below minimum")
   `OLAR_ASSERT_NEXT(a_exec_result, clock, reset, exec_go, rsp_valid_ff,
                     "finished item left no result")
   `OLAR_ASSERT(a_hit_in_list, clock, reset,
                (exec_go && (action_ff == ACTION_REMOVE) && hit_found) |->
                (CNT_W'(hit_pos) < count_ff),
                "removed position outside the list")

endmodule

@@ rtl/core/olar_cell.sv @@
// ----------------------------------------------------------------------------
// List cell
// Holds one entry, registers its match against the searched value, writes the
// appended value when selected, and takes its upper neighbor's entry on removal.
// ----------------------------------------------------------------------------
module olar_cell (
   input  logic                               clock,
   input  olar_pkg::cell_ctl_type             ctl,
   input  logic                               live,
   input  logic                               write_sel,
   input  logic                               hit_in,
   input  logic signed [olar_pkg::VALUE_W-1:0] next_entry,
   output logic signed [olar_pkg::VALUE_W-1:0] entry,
   output logic                               hit_out,
   output logic                               first
);
   import olar_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      match_ff;
   logic                      match_in;

   assign hit_out = hit_in | match_ff;
   assign first   = match_ff & ~hit_in;
   assign entry   = entry_ff;

   always_comb begin
      match_in = match_ff;
      if (ctl.compare) begin
         match_in = live && (entry_ff == ctl.value);
      end
      entry_in = entry_ff;
      if (ctl.append && write_sel) begin
         entry_in = ctl.value;
      end else if (ctl.shift && hit_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/core/olar_chain.sv @@
// ----------------------------------------------------------------------------
// Cell chain
// A row of list cells; the match flag ripples upward so that only the first
// match and the cells above it take part in a removal.
// ----------------------------------------------------------------------------
module olar_chain #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  olar_pkg::cell_ctl_type       ctl,
   input  logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         found,
   output logic [$clog2(DEPTH)-1:0]     position
);
   import olar_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   logic signed [VALUE_W-1:0] entry [DEPTH];
   logic [DEPTH:0]            hit;
   logic [DEPTH-1:0]          first;

   assign hit[0] = 1'b0;
   assign found  = hit[DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] upper;

      if (g == DEPTH - 1) begin : g_top
         assign upper = entry[g];
      end else begin : g_mid
         assign upper = entry[g+1];
      end

      olar_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .live       (count > CNT_W'(g)),
         .write_sel  (count == CNT_W'(g)),
         .hit_in     (hit[g]),
         .next_entry (upper),
         .entry      (entry[g]),
         .hit_out    (hit[g+1]),
         .first      (first[g])
      );
   end

   always_comb begin
      position = '0;
      for (int i = 0; i < DEPTH; i++) begin
         position = position | (first[i] ? IDX_W'(i) : '0);
      end
   end

endmodule
